// File: hdl/mdp_pkg.sv
// ----------------------------------------------------------------------------
// mdp_pkg
// Shared types, character codes and base codes for the method descriptor
// parser.
// ----------------------------------------------------------------------------
package mdp_pkg;

  localparam int unsigned MaxDimsDefault   = 255;
  localparam int unsigned MaxParamsDefault = 255;

  // descriptor characters
  localparam logic [7:0] CH_LPAREN = 8'h28;  // (
  localparam logic [7:0] CH_RPAREN = 8'h29;  // )
  localparam logic [7:0] CH_VOID   = 8'h56;  // V
  localparam logic [7:0] CH_OBJ    = 8'h4C;  // L
  localparam logic [7:0] CH_ARRAY  = 8'h5B;  // [
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;

  typedef enum logic [3:0] {
    BASE_NONE   = 4'd0,
    BASE_BYTE   = 4'd1,
    BASE_CHAR   = 4'd2,
    BASE_DOUBLE = 4'd3,
    BASE_FLOAT  = 4'd4,
    BASE_INT    = 4'd5,
    BASE_LONG   = 4'd6,
    BASE_SHORT  = 4'd7,
    BASE_BOOL   = 4'd8,
    BASE_OBJECT = 4'd9,
    BASE_VOID   = 4'd10
  } mdp_base_e;

  typedef enum logic [2:0] {
    PH_OPEN      = 3'd0,
    PH_PARAMS    = 3'd1,
    PH_PARAM_OBJ = 3'd2,
    PH_RETURN    = 3'd3,
    PH_RET_OBJ   = 3'd4,
    PH_DONE      = 3'd5
  } mdp_phase_e;

  typedef struct packed {
    mdp_phase_e phase;
    logic [7:0] dims_seen;
    logic [7:0] params_done;
    logic       error_flag;
  } mdp_state_t;

  typedef struct packed {
    logic       type_done;
    logic       is_return;
    logic [3:0] base_code;
    logic [7:0] array_depth;
    logic [7:0] param_number;
    logic       parse_ok;
    logic       parse_error;
  } mdp_res_t;

  localparam mdp_state_t StateReset = '{
    phase:       PH_OPEN,
    dims_seen:   8'd0,
    params_done: 8'd0,
    error_flag:  1'b0
  };

  function automatic mdp_base_e base_letter(logic [7:0] c);
    mdp_base_e b;
    unique case (c)
      8'h42:   b = BASE_BYTE;    // B
      8'h43:   b = BASE_CHAR;    // C
      8'h44:   b = BASE_DOUBLE;  // D
      8'h46:   b = BASE_FLOAT;   // F
      8'h49:   b = BASE_INT;     // I
      8'h4A:   b = BASE_LONG;    // J
      8'h53:   b = BASE_SHORT;   // S
      8'h5A:   b = BASE_BOOL;    // Z
      default: b = BASE_NONE;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/mdp_char_if.sv
// ----------------------------------------------------------------------------
// mdp_char_if
// Character channel: one descriptor byte and its last-character mark.
// ----------------------------------------------------------------------------
interface mdp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

// File: hdl/mdp_res_if.sv
// ----------------------------------------------------------------------------
// mdp_res_if
// Result channel: per-character parse report.
// ----------------------------------------------------------------------------
interface mdp_res_if;
  logic       valid;
  logic       ready;
  logic       type_done;
  logic       is_return;
  logic [3:0] base_code;
  logic [7:0] array_depth;
  logic [7:0] param_number;
  logic       parse_ok;
  logic       parse_error;

  modport source (
    output valid, output type_done, output is_return, output base_code,
    output array_depth, output param_number, output parse_ok, output parse_error,
    input  ready
  );
  modport sink (
    input  valid, input type_done, input is_return, input base_code,
    input  array_depth, input param_number, input parse_ok, input parse_error,
    output ready
  );
endinterface

// File: hdl/mdp_step.sv
// ----------------------------------------------------------------------------
// mdp_step
// Next-state and result logic for one descriptor character.
// ----------------------------------------------------------------------------
module mdp_step import mdp_pkg::*; #(
  parameter int unsigned MaxDims   = MaxDimsDefault,
  parameter int unsigned MaxParams = MaxParamsDefault
) (
  input  mdp_state_t st_i,
  input  logic [7:0] char_code_i,
  input  logic       final_char_i,
  output mdp_state_t st_o,
  output mdp_res_t   res_o
);

  localparam logic [7:0] DimsLim   = 8'(MaxDims);
  localparam logic [7:0] ParamsLim = 8'(MaxParams);

  mdp_state_t nst;
  mdp_base_e  letter;
  logic [3:0] base;
  logic       err;
  logic       ret_type;
  logic       is_ret;
  logic       done;
  logic       ok;

  assign letter = base_letter(char_code_i);

  always_comb begin
    nst      = st_i;
    base     = BASE_NONE;
    err      = st_i.error_flag;
    done     = 1'b0;
    ok       = 1'b0;
    is_ret   = (st_i.phase == PH_RETURN);
    ret_type = (st_i.phase == PH_RETURN) || (st_i.phase == PH_RET_OBJ);

    if (!st_i.error_flag) begin
      unique case (st_i.phase)
        PH_OPEN: begin
          if (char_code_i == CH_LPAREN) nst.phase = PH_PARAMS;
          else err = 1'b1;
        end
        PH_PARAMS, PH_RETURN: begin
          priority if (char_code_i == CH_ARRAY) begin
            if (st_i.dims_seen >= DimsLim) err = 1'b1;
            else nst.dims_seen = st_i.dims_seen + 8'd1;
          end else if (!is_ret && char_code_i == CH_RPAREN) begin
            if (st_i.dims_seen != 8'd0) err = 1'b1;
            else nst.phase = PH_RETURN;
          end else if (char_code_i == CH_OBJ) begin
            nst.phase = is_ret ? PH_RET_OBJ : PH_PARAM_OBJ;
          end else if (is_ret && char_code_i == CH_VOID) begin
            // an array of void is malformed
            if (st_i.dims_seen != 8'd0) err = 1'b1;
            else base = BASE_VOID;
          end else if (letter != BASE_NONE) begin
            base = letter;
          end else begin
            err = 1'b1;
          end
        end
        PH_PARAM_OBJ, PH_RET_OBJ: begin
          // any byte but ';' is part of the class name
          if (char_code_i == CH_SEMI) base = BASE_OBJECT;
        end
        default: err = 1'b1;
      endcase

      if (!err && base != BASE_NONE) begin
        if (!ret_type && st_i.params_done >= ParamsLim) begin
          err = 1'b1;
        end else begin
          done          = 1'b1;
          nst.dims_seen = 8'd0;
          if (ret_type) begin
            nst.phase = PH_DONE;
          end else begin
            nst.params_done = st_i.params_done + 8'd1;
            nst.phase       = PH_PARAMS;
          end
        end
      end
    end

    if (final_char_i) begin
      if (!err && nst.phase == PH_DONE) ok = 1'b1;
      else err = 1'b1;
    end

    nst.error_flag = err;
    st_o = final_char_i ? StateReset : nst;

    res_o.type_done    = done;
    res_o.is_return    = done & ret_type;
    res_o.base_code    = done ? base : BASE_NONE;
    res_o.array_depth  = done ? st_i.dims_seen : 8'd0;
    res_o.param_number = done ? st_i.params_done : 8'd0;
    res_o.parse_ok     = ok;
    res_o.parse_error  = err;
  end

endmodule

// File: hdl/method_descriptor_parser_unit.sv
// ----------------------------------------------------------------------------
// method_descriptor_parser_unit
// Streaming checker and type splitter for method type descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   char_i carries one descriptor byte per item plus final_char, which marks
//   the last byte of a descriptor. For every byte taken, res_o delivers one
//   item: type_done with base code, array depth, parameter index and the
//   return flag when that byte closes a type; parse_ok on the last byte of a
//   well-formed descriptor; parse_error once the descriptor is malformed.
//   After the final byte the parser is back at its start state.
// Timing:
//   An item is latched in the input register, evaluated combinationally
//   against the parse state and written to the result register once that
//   register is free or its result is being taken. Throughput is one byte
//   per cycle while res_o.ready stays high; the next parse state is formed
//   combinationally between input and result register.
// Reset:
//   rst_ni clears both pipeline valids and returns the parser to "expect
//   open parenthesis" with no error and zero counts.
// Stall:
//   With res_o.ready low the result holds, the input register still fills,
//   and char_i.ready drops only once both registers are occupied.
// ----------------------------------------------------------------------------
module method_descriptor_parser_unit import mdp_pkg::*; #(
  parameter int unsigned MaxDims   = MaxDimsDefault,
  parameter int unsigned MaxParams = MaxParamsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mdp_char_if.sink  char_i,
  mdp_res_if.source res_o
);

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_fin_q;
  logic       out_valid_q;
  mdp_res_t   res_q;
  mdp_res_t   res_d;
  mdp_state_t st_q;
  mdp_state_t st_d;
  logic       adv;

  assign adv          = in_valid_q && (!out_valid_q || res_o.ready);
  assign char_i.ready = !in_valid_q || adv;

  mdp_step #(
    .MaxDims   (MaxDims),
    .MaxParams (MaxParams)
  ) u_step (
    .st_i         (st_q),
    .char_code_i  (in_char_q),
    .final_char_i (in_fin_q),
    .st_o         (st_d),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= StateReset;
    end else begin
      if (char_i.ready) in_valid_q <= char_i.valid;
      if (adv) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      in_char_q <= char_i.char_code;
      in_fin_q  <= char_i.final_char;
    end
    if (adv) res_q <= res_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.type_done    = res_q.type_done;
  assign res_o.is_return    = res_q.is_return;
  assign res_o.base_code    = res_q.base_code;
  assign res_o.array_depth  = res_q.array_depth;
  assign res_o.param_number = res_q.param_number;
  assign res_o.parse_ok     = res_q.parse_ok;
  assign res_o.parse_error  = res_q.parse_error;

endmodule

// File: hdl/mdp_checker.sv
// ----------------------------------------------------------------------------
// mdp_checker
// Port-level checks on the parser's result stream.
// ----------------------------------------------------------------------------
module mdp_checker import mdp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       type_done_i,
  input logic       is_return_i,
  input logic [3:0] base_code_i,
  input logic [7:0] array_depth_i,
  input logic [7:0] param_number_i,
  input logic       parse_ok_i,
  input logic       parse_error_i
);

  // a stalled result keeps its report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(type_done_i)
      && $stable(base_code_i) && $stable(parse_ok_i) && $stable(parse_error_i))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !(parse_ok_i && parse_error_i))
    else $error("ok and error both set");

  // no type reported: all type fields zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !type_done_i |-> base_code_i == BASE_NONE && !is_return_i
      && array_depth_i == 8'd0 && param_number_i == 8'd0)
    else $error("type fields set without a completed type");

  // a completed type has a base code, and void only as the return type;
  // a final byte that closes a parameter still reports it with an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && type_done_i |-> base_code_i != BASE_NONE
      && (is_return_i || base_code_i != BASE_VOID))
    else $error("bad completed type");

endmodule

bind method_descriptor_parser_unit mdp_checker u_mdp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .type_done_i    (res_o.type_done),
  .is_return_i    (res_o.is_return),
  .base_code_i    (res_o.base_code),
  .array_depth_i  (res_o.array_depth),
  .param_number_i (res_o.param_number),
  .parse_ok_i     (res_o.parse_ok),
  .parse_error_i  (res_o.parse_error)
);
